### hdl/ipv4hc_pkg.sv
// Package: verdict codes, IPv4 field constants and header word positions.
package ipv4hc_pkg;

    typedef enum logic [2:0] {
        VERDICT_ACCEPT      = 3'd0,
        VERDICT_BAD_VERSION = 3'd1,
        VERDICT_SHORT_IHL   = 3'd2,
        VERDICT_BAD_LENGTH  = 3'd3,
        VERDICT_BAD_CSUM    = 3'd4,
        VERDICT_NOT_ICMP    = 3'd5,
        VERDICT_WRONG_DEST  = 3'd6
    } verdict_t;

    localparam logic [3:0]  IP_VERSION = 4'd4;
    localparam logic [3:0]  MIN_IHL    = 4'd5;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [31:0] BCAST_ADDR = 32'hFFFF_FFFF;
    localparam logic [15:0] CSUM_GOOD  = 16'hFFFF;

    // Word positions inside the header (word 0 is the flagged first word)
    localparam logic [4:0] WORD_TOTAL_LEN = 5'd1;
    localparam logic [4:0] WORD_PROTOCOL  = 5'd4;
    localparam logic [4:0] WORD_SRC_HI    = 5'd6;
    localparam logic [4:0] WORD_SRC_LO    = 5'd7;
    localparam logic [4:0] WORD_DST_HI    = 5'd8;
    localparam logic [4:0] WORD_DST_LO    = 5'd9;

endpackage

### hdl/ipv4hc_ifs.sv
// Interfaces: header word channel, verdict channel and local address write channel.
interface ipv4hc_hdr_if;
    logic        valid;
    logic        ready;
    logic [15:0] header_word;
    logic        first_word;

    modport source (output valid, output header_word, output first_word, input ready);
    modport sink   (input valid, input header_word, input first_word, output ready);
endinterface

interface ipv4hc_res_if;
    logic                 valid;
    logic                 ready;
    ipv4hc_pkg::verdict_t verdict;
    logic [5:0]           header_bytes;
    logic [31:0]          source_addr;
    logic [15:0]          total_length;

    modport source (output valid, output verdict, output header_bytes, output source_addr,
                    output total_length, input ready);
    modport sink   (input valid, input verdict, input header_bytes, input source_addr,
                    input total_length, output ready);
endinterface

interface ipv4hc_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] local_addr;

    modport source (output valid, output local_addr, input ready);
    modport sink   (input valid, input local_addr, output ready);
endinterface

### hdl/ipv4_receive_header_check.sv
// Top level: IPv4 receive header check, one header word per cycle, one verdict per packet.
// The verdict is registered: it is on the result port in the cycle after the word that decides it.
// Throughput: one header word per cycle; the result register takes a new verdict in the
//   same cycle the old one is taken, so only a stalled result holds up the input.
// Reset (rst_n low, asynchronous): header tracking goes idle, the result register
//   empties and local_addr clears to zero.
module ipv4_receive_header_check
(
    input  logic                 clk,
    input  logic                 rst_n,
    ipv4hc_hdr_if.sink           hdr,
    ipv4hc_res_if.source         result,
    ipv4hc_cfg_if.sink           cfg
);

    // ------------------------------------------------------------------
    // Configuration: local address, written whenever offered
    // ------------------------------------------------------------------
    logic [31:0] local_addr_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg <= '0;
        end
        else if (cfg.valid)
        begin
            local_addr_reg <= cfg.local_addr;
        end
    end

    // ------------------------------------------------------------------
    // Header tracking state
    // ------------------------------------------------------------------
    logic        active_reg,    active_next;
    logic [4:0]  word_index_reg, word_index_next;
    logic [4:0]  hdr_words_reg, hdr_words_next;   // header length in 16-bit words
    logic [15:0] sum_reg,       sum_next;         // ones-complement running sum
    logic [15:0] length_reg,    length_next;
    logic [7:0]  protocol_reg,  protocol_next;
    logic [31:0] source_reg,    source_next;
    logic [31:0] dest_reg,      dest_next;

    // Result register
    logic                 res_valid_reg;
    ipv4hc_pkg::verdict_t verdict_reg;
    logic [5:0]           header_bytes_reg;
    logic [31:0]          source_addr_reg;
    logic [15:0]          total_length_reg;

    // Result produced by the current word
    logic                 emit;
    ipv4hc_pkg::verdict_t verdict_new;
    logic [5:0]           header_bytes_new;
    logic [31:0]          source_addr_new;
    logic [15:0]          total_length_new;

    logic        hdr_fire;
    logic [3:0]  version;
    logic [3:0]  ihl;
    logic [16:0] sum_wide;
    logic [15:0] sum_folded;
    logic [5:0]  end_bytes;

    // Take a word whenever the result register is empty or being emptied now
    assign hdr.ready = !res_valid_reg || result.ready;
    assign hdr_fire  = hdr.valid && hdr.ready;

    assign version = hdr.header_word[15:12];
    assign ihl     = hdr.header_word[11:8];

    // End-around carry add; the fold never carries again
    assign sum_wide   = {1'b0, sum_reg} + {1'b0, hdr.header_word};
    assign sum_folded = sum_wide[15:0] + {15'd0, sum_wide[16]};

    assign end_bytes = {hdr_words_reg, 1'b0};

    always_comb
    begin
        active_next      = active_reg;
        word_index_next  = word_index_reg;
        hdr_words_next   = hdr_words_reg;
        sum_next         = sum_reg;
        length_next      = length_reg;
        protocol_next    = protocol_reg;
        source_next      = source_reg;
        dest_next        = dest_reg;
        emit             = 1'b0;
        verdict_new      = ipv4hc_pkg::VERDICT_ACCEPT;
        header_bytes_new = end_bytes;
        source_addr_new  = '0;
        total_length_new = '0;

        if (hdr_fire)
        begin
            if (hdr.first_word)
            begin
                // Restart: drop any open header and check word 0 at once
                active_next      = 1'b0;
                word_index_next  = '0;
                hdr_words_next   = {ihl, 1'b0};
                sum_next         = '0;
                length_next      = '0;
                protocol_next    = '0;
                source_next      = '0;
                dest_next        = '0;
                header_bytes_new = {ihl, 2'b00};
                if (version != ipv4hc_pkg::IP_VERSION)
                begin
                    emit        = 1'b1;
                    verdict_new = ipv4hc_pkg::VERDICT_BAD_VERSION;
                end
                else if (ihl < ipv4hc_pkg::MIN_IHL)
                begin
                    emit        = 1'b1;
                    verdict_new = ipv4hc_pkg::VERDICT_SHORT_IHL;
                end
                else
                begin
                    active_next     = 1'b1;
                    sum_next        = hdr.header_word;
                    word_index_next = 5'd1;
                end
            end
            else if (active_reg)
            begin
                sum_next = sum_folded;
                unique case (word_index_reg)
                    ipv4hc_pkg::WORD_TOTAL_LEN: length_next = hdr.header_word;
                    ipv4hc_pkg::WORD_PROTOCOL:  protocol_next = hdr.header_word[7:0];
                    ipv4hc_pkg::WORD_SRC_HI:    source_next = {hdr.header_word, source_reg[15:0]};
                    ipv4hc_pkg::WORD_SRC_LO:    source_next = {source_reg[31:16], hdr.header_word};
                    ipv4hc_pkg::WORD_DST_HI:    dest_next = {hdr.header_word, dest_reg[15:0]};
                    ipv4hc_pkg::WORD_DST_LO:    dest_next = {dest_reg[31:16], hdr.header_word};
                    default:                    ;
                endcase
                word_index_next = word_index_reg + 5'd1;

                // Last header word: close the header and rank the checks
                if (word_index_next >= hdr_words_reg)
                begin
                    active_next      = 1'b0;
                    emit             = 1'b1;
                    total_length_new = length_next;
                    if (length_next < {10'd0, end_bytes})
                    begin
                        verdict_new = ipv4hc_pkg::VERDICT_BAD_LENGTH;
                    end
                    else if (sum_next != ipv4hc_pkg::CSUM_GOOD)
                    begin
                        verdict_new = ipv4hc_pkg::VERDICT_BAD_CSUM;
                    end
                    else if (protocol_next != ipv4hc_pkg::PROTO_ICMP)
                    begin
                        verdict_new = ipv4hc_pkg::VERDICT_NOT_ICMP;
                    end
                    else if (dest_next != local_addr_reg && dest_next != ipv4hc_pkg::BCAST_ADDR)
                    begin
                        verdict_new = ipv4hc_pkg::VERDICT_WRONG_DEST;
                    end
                    else
                    begin
                        verdict_new     = ipv4hc_pkg::VERDICT_ACCEPT;
                        source_addr_new = source_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            word_index_reg <= '0;
            hdr_words_reg  <= '0;
            sum_reg        <= '0;
            length_reg     <= '0;
            protocol_reg   <= '0;
            source_reg     <= '0;
            dest_reg       <= '0;
        end
        else
        begin
            active_reg     <= active_next;
            word_index_reg <= word_index_next;
            hdr_words_reg  <= hdr_words_next;
            sum_reg        <= sum_next;
            length_reg     <= length_next;
            protocol_reg   <= protocol_next;
            source_reg     <= source_next;
            dest_reg       <= dest_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: load a new verdict, else drop the one just taken
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            verdict_reg      <= verdict_new;
            header_bytes_reg <= header_bytes_new;
            source_addr_reg  <= source_addr_new;
            total_length_reg <= total_length_new;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.verdict      = verdict_reg;
    assign result.header_bytes = header_bytes_reg;
    assign result.source_addr  = source_addr_reg;
    assign result.total_length = total_length_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A new verdict appears only after an accepted word
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !$past(res_valid_reg)) |-> $past(hdr_fire))
        else $error("verdict without an accepted word");

    // An open header always has words left to come
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (word_index_reg != 5'd0) && (word_index_reg < hdr_words_reg)
                       && (hdr_words_reg >= {ipv4hc_pkg::MIN_IHL, 1'b0}))
        else $error("open header past its end");

    // An accepted packet never has a total length shorter than its header
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && verdict_reg == ipv4hc_pkg::VERDICT_ACCEPT)
            |-> (total_length_reg >= {10'd0, header_bytes_reg}))
        else $error("accepted packet with short total length");

endmodule

### bench/tb_top.sv
// Testbench for ipv4_receive_header_check: directed and random header streams checked against a predictor.
`timescale 1ns / 1ps

module tb_top;

    // Cycles with no item moving on any channel before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // Target number of header words per random phase
    localparam int PHASE_WORDS = 440;

    // One expected verdict as it should leave the result channel
    typedef struct {
        ipv4hc_pkg::verdict_t verdict;
        logic [5:0]           header_bytes;
        logic [31:0]          source_addr;
        logic [15:0]          total_length;
    } verdict_rec_t;

    // Kinds of damage the packet builder can apply to a header
    typedef enum int {
        FLAW_NONE,
        FLAW_LENGTH,
        FLAW_CSUM,
        FLAW_PROTOCOL,
        FLAW_DEST
    } pkt_flaw_t;

    // Tracks the header parser state word by word and holds the verdicts still owed
    class verdict_tracker_t;
        logic [31:0]  local_addr = '0;
        bit           open_hdr   = 1'b0;
        logic [4:0]   word_pos   = '0;
        logic [4:0]   hdr_words  = '0;
        logic [15:0]  csum       = '0;
        logic [15:0]  cap_len    = '0;
        logic [7:0]   cap_proto  = '0;
        logic [31:0]  cap_src    = '0;
        logic [31:0]  cap_dst    = '0;
        verdict_rec_t expected_verdicts[$];
        int           failures   = 0;

        // Ones-complement 16-bit add with end-around carry
        static function logic [15:0] fold_add(logic [15:0] a, logic [15:0] b);
            logic [16:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[15:0] + {15'd0, s[16]};
        endfunction

        function void owe(ipv4hc_pkg::verdict_t v, logic [5:0] hb, logic [31:0] src,
                          logic [15:0] len);
            verdict_rec_t r;
            r.verdict      = v;
            r.header_bytes = hb;
            r.source_addr  = src;
            r.total_length = len;
            expected_verdicts.push_back(r);
        endfunction

        // Advance the parser by one accepted header word
        function void note_word(logic [15:0] w, logic first);
            ipv4hc_pkg::verdict_t v;
            if (first)
            begin
                open_hdr  = 1'b0;
                word_pos  = '0;
                hdr_words = {w[11:8], 1'b0};
                csum      = '0;
                cap_len   = '0;
                cap_proto = '0;
                cap_src   = '0;
                cap_dst   = '0;
                if (w[15:12] != ipv4hc_pkg::IP_VERSION)
                    owe(ipv4hc_pkg::VERDICT_BAD_VERSION, {w[11:8], 2'b00}, '0, '0);
                else if (w[11:8] < ipv4hc_pkg::MIN_IHL)
                    owe(ipv4hc_pkg::VERDICT_SHORT_IHL, {w[11:8], 2'b00}, '0, '0);
                else
                begin
                    open_hdr = 1'b1;
                    csum     = fold_add(16'h0000, w);
                    word_pos = 5'd1;
                end
            end
            else if (open_hdr)
            begin
                csum = fold_add(csum, w);
                unique case (word_pos)
                    ipv4hc_pkg::WORD_TOTAL_LEN: cap_len         = w;
                    ipv4hc_pkg::WORD_PROTOCOL:  cap_proto       = w[7:0];
                    ipv4hc_pkg::WORD_SRC_HI:    cap_src[31:16]  = w;
                    ipv4hc_pkg::WORD_SRC_LO:    cap_src[15:0]   = w;
                    ipv4hc_pkg::WORD_DST_HI:    cap_dst[31:16]  = w;
                    ipv4hc_pkg::WORD_DST_LO:    cap_dst[15:0]   = w;
                    default: ;
                endcase
                word_pos = word_pos + 5'd1;
                if (word_pos >= hdr_words)
                begin
                    open_hdr = 1'b0;
                    if (cap_len < {hdr_words, 1'b0})
                        v = ipv4hc_pkg::VERDICT_BAD_LENGTH;
                    else if (csum != ipv4hc_pkg::CSUM_GOOD)
                        v = ipv4hc_pkg::VERDICT_BAD_CSUM;
                    else if (cap_proto != ipv4hc_pkg::PROTO_ICMP)
                        v = ipv4hc_pkg::VERDICT_NOT_ICMP;
                    else if (cap_dst != local_addr && cap_dst != ipv4hc_pkg::BCAST_ADDR)
                        v = ipv4hc_pkg::VERDICT_WRONG_DEST;
                    else
                        v = ipv4hc_pkg::VERDICT_ACCEPT;
                    owe(v, {hdr_words, 1'b0},
                        (v == ipv4hc_pkg::VERDICT_ACCEPT) ? cap_src : 32'd0, cap_len);
                end
            end
        endfunction

        // Compare one delivered verdict with the oldest one owed
        function void check_verdict(ipv4hc_pkg::verdict_t v, logic [5:0] hb,
                                    logic [31:0] src, logic [15:0] len);
            verdict_rec_t e;
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: unexpected verdict %0d, none pending", $time, v);
                failures++;
                return;
            end
            e = expected_verdicts.pop_front();
            if (v !== e.verdict)
            begin
                $display("%0t: verdict expected %0d got %0d", $time, e.verdict, v);
                failures++;
            end
            if (hb !== e.header_bytes)
            begin
                $display("%0t: header_bytes expected %0d got %0d", $time, e.header_bytes, hb);
                failures++;
            end
            if (src !== e.source_addr)
            begin
                $display("%0t: source_addr expected %h got %h", $time, e.source_addr, src);
                failures++;
            end
            if (len !== e.total_length)
            begin
                $display("%0t: total_length expected %h got %h", $time, e.total_length, len);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ipv4hc_hdr_if hdr_ch ();
    ipv4hc_res_if res_ch ();
    ipv4hc_cfg_if cfg_ch ();

    verdict_tracker_t tracker;
    logic [15:0]      pkt_q[$];        // header under construction
    logic [31:0]      cur_local;       // local address last written to the block
    int               send_idle_pct;   // chance that the sender idles before each item
    int               stall_pct;       // chance per cycle that the receiver stalls
    int               quiet_cycles;

    ipv4_receive_header_check DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .hdr    (hdr_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always #5 clk = ~clk;

    // Receiver: decide ready on the falling edge so it is stable at the rising edge
    always @(negedge clk)
    begin
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Check every verdict taken at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            tracker.check_verdict(res_ch.verdict, res_ch.header_bytes, res_ch.source_addr,
                                  res_ch.total_length);
    end

    // Watchdog: end the run if no channel moves an item for too long
    always @(posedge clk)
    begin
        if ((hdr_ch.valid && hdr_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Send one header word; called and returning at a falling edge. Valid stays high
    // on return so back-to-back words go out without a bubble.
    task automatic send_word(input logic [15:0] w, input logic first);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            hdr_ch.valid <= 1'b0;
            @(negedge clk);
        end
        hdr_ch.valid       <= 1'b1;
        hdr_ch.header_word <= w;
        hdr_ch.first_word  <= first;
        do
            @(posedge clk);
        while (!hdr_ch.ready);
        tracker.note_word(w, first);
        @(negedge clk);
    endtask

    // Write the local address; the block must be idle
    task automatic write_local_addr(input logic [31:0] addr);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.local_addr <= addr;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        tracker.local_addr = addr;
        cur_local          = addr;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Hold the sender until every owed verdict has come, then let the pipeline settle
    task automatic drain_verdicts();
        hdr_ch.valid <= 1'b0;
        while (tracker.expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Build one IPv4 header into pkt_q with a correct checksum unless told otherwise
    task automatic build_header(input pkt_flaw_t flaw, input logic [3:0] ihl);
        logic [5:0]  hb;
        logic [15:0] tlen;
        logic [15:0] sum;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        int          n;
        hb = {ihl, 2'b00};
        // Total length: below the header for a length flaw, else often exactly the header
        if (flaw == FLAW_LENGTH)
            tlen = 16'($urandom_range(0, int'(hb) - 1));
        else if ($urandom_range(0, 3) == 0)
            tlen = {10'd0, hb};
        else
            tlen = 16'($urandom_range(int'(hb), 65535));
        proto = (flaw == FLAW_PROTOCOL) ? 8'($urandom) : ipv4hc_pkg::PROTO_ICMP;
        if (flaw == FLAW_DEST)
            dst = $urandom;
        else
            dst = ($urandom_range(0, 2) == 0) ? ipv4hc_pkg::BCAST_ADDR : cur_local;
        src  = $urandom;
        pkt_q = {};
        pkt_q.push_back({ipv4hc_pkg::IP_VERSION, ihl, 8'($urandom)});  // version, IHL, TOS
        pkt_q.push_back(tlen);
        pkt_q.push_back(16'($urandom));                    // identification
        pkt_q.push_back(16'($urandom));                    // flags and fragment offset
        pkt_q.push_back({8'($urandom), proto});            // TTL, protocol
        pkt_q.push_back(16'h0000);                         // checksum, filled below
        pkt_q.push_back(src[31:16]);
        pkt_q.push_back(src[15:0]);
        pkt_q.push_back(dst[31:16]);
        pkt_q.push_back(dst[15:0]);
        for (n = 10; n < 2 * int'(ihl); n++)
            pkt_q.push_back(16'($urandom));                // options
        sum = 16'h0000;
        for (n = 0; n < pkt_q.size(); n++)
            sum = verdict_tracker_t::fold_add(sum, pkt_q[n]);
        pkt_q[5] = ~sum;
        if (flaw == FLAW_CSUM)
            pkt_q[5] = pkt_q[5] ^ 16'($urandom_range(1, 16'hFFFF));
    endtask

    // Short hand-picked sequence: single-word drops, stray words, a clean accept with
    // payload, and a header cut short by a new first word
    task automatic run_directed();
        int i;
        send_word(16'h0000, 1'b1);   // version 0, IHL 0
        send_word(16'hFFFF, 1'b1);   // version 15, largest IHL
        send_word(16'h4000, 1'b1);   // right version, IHL 0
        send_word(16'h4400, 1'b1);   // IHL one below the minimum
        send_word(16'hFFFF, 1'b0);   // stray words while idle
        send_word(16'h0000, 1'b0);
        build_header(FLAW_NONE, ipv4hc_pkg::MIN_IHL);
        for (i = 0; i < pkt_q.size(); i++)
            send_word(pkt_q[i], i == 0);
        send_word(16'hA5A5, 1'b0);   // payload after the header
        send_word(16'h4500, 1'b1);   // open a header, then restart it
        send_word(16'h0040, 1'b0);
        send_word(16'h1234, 1'b0);
        send_word(16'h3FFF, 1'b1);
    endtask

    // Mostly well-formed headers with random content; some damaged, cut short or lone
    task automatic run_phase(input int words_goal);
        int          sent;
        int          roll;
        int          cut;
        int          i;
        pkt_flaw_t   flaw;
        logic [3:0]  ihl;
        sent = 0;
        while (sent < words_goal)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
            begin
                // lone first word, any content
                send_word(16'($urandom), 1'b1);
                sent++;
            end
            else if (roll < 8)
            begin
                // version right but IHL too small
                send_word({ipv4hc_pkg::IP_VERSION, 4'($urandom_range(0, 4)), 8'($urandom)},
                          1'b1);
                sent++;
            end
            else
            begin
                if (roll < 64)
                    flaw = FLAW_NONE;
                else if (roll < 73)
                    flaw = FLAW_LENGTH;
                else if (roll < 82)
                    flaw = FLAW_CSUM;
                else if (roll < 91)
                    flaw = FLAW_PROTOCOL;
                else
                    flaw = FLAW_DEST;
                ihl = ($urandom_range(0, 9) < 7) ? ipv4hc_pkg::MIN_IHL
                                                 : 4'($urandom_range(6, 15));
                build_header(flaw, ihl);
                cut = pkt_q.size();
                // drop the tail now and then so the next first word restarts mid-header
                if ($urandom_range(0, 99) < 8)
                    cut = $urandom_range(1, pkt_q.size() - 1);
                for (i = 0; i < cut; i++)
                    send_word(pkt_q[i], i == 0);
                sent += cut;
                repeat ($urandom_range(0, 3))
                    send_word(16'($urandom), 1'b0);
            end
        end
        // close an open header with a bad-version word so the phase ends idle
        if (tracker.open_hdr)
            send_word(16'h0000, 1'b1);
    endtask

    initial
    begin
        logic [31:0] addr_plan[4];
        int          idle_plan[4];
        int          stall_plan[4];
        int          ph;
        addr_plan  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0A00_0001, 32'h0};
        idle_plan  = '{0, 73, 0, 16};
        stall_plan = '{0, 0, 73, 16};
        addr_plan[3] = $urandom;
        tracker      = new;
        clk          = 1'b0;
        rst_n        = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        cur_local     = '0;
        hdr_ch.valid       = 1'b0;
        hdr_ch.header_word = '0;
        hdr_ch.first_word  = 1'b0;
        res_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.local_addr  = '0;

        // Hold reset, then release it on a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_local_addr(32'hC0A8_0001);
        run_directed();

        // Each phase: pause the sender until idle, move the local address, then run
        for (ph = 0; ph < 4; ph++)
        begin
            drain_verdicts();
            write_local_addr(addr_plan[ph]);
            send_idle_pct = idle_plan[ph];
            stall_pct     = stall_plan[ph];
            run_phase(PHASE_WORDS);
        end
        drain_verdicts();

        if (tracker.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
